/* rtl/mips_pkg.sv */
// shared widths and register codes for the periodic minimum-image separation pipeline
// no dependencies
`default_nettype none

package mips_pkg;

    localparam int POS_W   = 32;
    localparam int LEN_W   = 31;
    localparam int DIF_W   = 33;
    localparam int MAG_W   = 33;
    localparam int SQR_W   = 66;
    localparam int REM_W   = 67;
    localparam int ROOT_W  = 33;
    localparam int QUO_W   = 31;
    localparam int NUM_W   = 63;
    localparam int SQ_STEPS = 33;
    localparam int DV_STEPS = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 31'd65536;
    localparam logic [QUO_W-1:0] COS_ONE   = 31'h4000_0000;

endpackage

`default_nettype wire

/* rtl/min_image_pair_separation_top.sv */
// pair separation and polar cosine under periodic minimum-image wrap
// depends on mips_pkg
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid / s_tready       s_tdata: first x,y,z then second x,y,z
//  m_*      out  m_tvalid / m_tready       m_tdata: separation, polar cosine; m_tuser: coincident
//  cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data (box length x, y, z)
//
// one pair per cycle while the result is not stalled
// the square root has 33 stages and the divider 31 stages, one bit per stage
// i_rst_n clears the valid bits and sets each box length to 1.0
// a stalled result freezes the whole pipeline; input is taken whenever the output slot is free
`default_nettype none

module min_image_pair_separation_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // first_x, first_y, first_z, second_x, second_y, second_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // separation, polar_cosine
    output logic              m_tuser,   // coincident
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [mips_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mips_pkg::LEN_W-1:0]     i_cfg_data
);

    localparam int SQ = mips_pkg::SQ_STEPS;
    localparam int DV = mips_pkg::DV_STEPS;

    logic w_en;
    logic r_out_vld;

    logic [mips_pkg::LEN_W-1:0] r_len_x, r_len_y, r_len_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_x <= mips_pkg::LEN_RESET;
            r_len_y <= mips_pkg::LEN_RESET;
            r_len_z <= mips_pkg::LEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mips_pkg::CFG_BOX_X: r_len_x <= i_cfg_data;
                mips_pkg::CFG_BOX_Y: r_len_y <= i_cfg_data;
                mips_pkg::CFG_BOX_Z: r_len_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en     = !r_out_vld || m_tready;
    assign s_tready = w_en;

    // stage a: raw differences
    logic                              r_a_vld;
    logic signed [mips_pkg::DIF_W-1:0] r_a_dx, r_a_dy, r_a_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx <= {s_tdata[31], s_tdata[31:0]}   - {s_tdata[127], s_tdata[127:96]};
            r_a_dy <= {s_tdata[63], s_tdata[63:32]}  - {s_tdata[159], s_tdata[159:128]};
            r_a_dz <= {s_tdata[95], s_tdata[95:64]}  - {s_tdata[191], s_tdata[191:160]};
        end
    end

    // stage b: wrap and magnitude
    function automatic logic [34:0] wrap_axis(input logic signed [32:0] d,
                                              input logic [30:0] len);
        logic signed [33:0] v_d, v_lo, v_hi, v_sel;
        logic [33:0] v_md, v_mlo, v_mhi;
        v_d   = {d[32], d};
        v_lo  = v_d - $signed({3'd0, len});
        v_hi  = v_d + $signed({3'd0, len});
        v_md  = v_d[33]  ? 34'(-v_d)  : 34'(v_d);
        v_mlo = v_lo[33] ? 34'(-v_lo) : 34'(v_lo);
        v_mhi = v_hi[33] ? 34'(-v_hi) : 34'(v_hi);
        if (v_mlo < v_md) begin
            v_sel = v_lo;
        end else if (v_mhi < v_md) begin
            v_sel = v_hi;
        end else begin
            v_sel = v_d;
        end
        wrap_axis = {v_sel[33], v_sel[33] ? 34'(-v_sel) : 34'(v_sel)};
    endfunction

    logic                        r_b_vld;
    logic [mips_pkg::MAG_W-1:0]  r_b_mx, r_b_my, r_b_mz;
    logic                        r_b_neg;
    logic [34:0]                 w_wx, w_wy, w_wz;

    assign w_wx = wrap_axis(r_a_dx, r_len_x);
    assign w_wy = wrap_axis(r_a_dy, r_len_y);
    assign w_wz = wrap_axis(r_a_dz, r_len_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_mx  <= w_wx[32:0];
            r_b_my  <= w_wy[32:0];
            r_b_mz  <= w_wz[32:0];
            r_b_neg <= w_wz[34];
        end
    end

    // stage c: squares
    logic                        r_c_vld;
    logic [mips_pkg::SQR_W-1:0]  r_c_sx, r_c_sy, r_c_sz;
    logic [mips_pkg::MAG_W-1:0]  r_c_mz;
    logic                        r_c_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_sx  <= r_b_mx * r_b_mx;
            r_c_sy  <= r_b_my * r_b_my;
            r_c_sz  <= r_b_mz * r_b_mz;
            r_c_mz  <= r_b_mz;
            r_c_neg <= r_b_neg;
        end
    end

    localparam logic [mips_pkg::ROOT_W-1:0] ROOT1 = 1;
    localparam logic [mips_pkg::QUO_W-1:0]  QUO1  = 1;

    // square root, one root bit per stage; entry 0 holds the sum
    logic                         r_sq_vld  [0:SQ];
    logic [mips_pkg::REM_W-1:0]   r_sq_rem  [0:SQ];
    logic [mips_pkg::ROOT_W-1:0]  r_sq_root [0:SQ];
    logic [mips_pkg::MAG_W-1:0]   r_sq_mz   [0:SQ];
    logic                         r_sq_neg  [0:SQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_rem[0]  <= {1'b0, r_c_sx} + {1'b0, r_c_sy} + {1'b0, r_c_sz};
            r_sq_root[0] <= '0;
            r_sq_mz[0]   <= r_c_mz;
            r_sq_neg[0]  <= r_c_neg;
        end
    end

    for (genvar k = 0; k < SQ; k++) begin : g_sq
        localparam int BIT = SQ - 1 - k;
        logic [mips_pkg::REM_W-1:0] w_trial;
        logic                       w_take;

        assign w_trial = ({{(mips_pkg::REM_W-mips_pkg::ROOT_W){1'b0}}, r_sq_root[k]} << (BIT + 1))
                       | ({{(mips_pkg::REM_W-1){1'b0}}, 1'b1} << (2 * BIT));
        assign w_take  = w_trial <= r_sq_rem[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k+1]  <= w_take ? r_sq_rem[k] - w_trial : r_sq_rem[k];
                r_sq_root[k+1] <= w_take ? r_sq_root[k] | (ROOT1 << BIT) : r_sq_root[k];
                r_sq_mz[k+1]   <= r_sq_mz[k];
                r_sq_neg[k+1]  <= r_sq_neg[k];
            end
        end
    end

    // restoring divide of |dz| * 2^30 by the root, one quotient bit per stage
    logic                         r_dv_vld [0:DV];
    logic [mips_pkg::NUM_W-1:0]   r_dv_rem [0:DV];
    logic [mips_pkg::ROOT_W-1:0]  r_dv_den [0:DV];
    logic [mips_pkg::QUO_W-1:0]   r_dv_q   [0:DV];
    logic                         r_dv_neg [0:DV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r_sq_vld[SQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rem[0] <= {r_sq_mz[SQ], 30'd0};
            r_dv_den[0] <= r_sq_root[SQ];
            r_dv_q[0]   <= '0;
            r_dv_neg[0] <= r_sq_neg[SQ];
        end
    end

    for (genvar j = 0; j < DV; j++) begin : g_dv
        localparam int BIT = DV - 1 - j;
        logic [63:0] w_sub;
        logic        w_take;

        assign w_sub  = {31'd0, r_dv_den[j]} << BIT;
        assign w_take = {1'b0, r_dv_rem[j]} >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[j+1] <= w_take ? r_dv_rem[j] - w_sub[62:0] : r_dv_rem[j];
                r_dv_q[j+1]   <= w_take ? r_dv_q[j] | (QUO1 << BIT) : r_dv_q[j];
                r_dv_den[j+1] <= r_dv_den[j];
                r_dv_neg[j+1] <= r_dv_neg[j];
            end
        end
    end

    // output register
    logic [mips_pkg::QUO_W-1:0] w_q;
    logic                       w_coin;
    logic [31:0]                n_cos, n_sep;
    logic [31:0]                r_out_sep, r_out_cos;
    logic                       r_out_coin;

    assign w_q    = (r_dv_q[DV] > mips_pkg::COS_ONE) ? mips_pkg::COS_ONE : r_dv_q[DV];
    assign w_coin = r_dv_den[DV] == '0;
    assign n_sep  = r_dv_den[DV][32] ? 32'hFFFF_FFFF : r_dv_den[DV][31:0];
    assign n_cos  = w_coin ? 32'd0 : (r_dv_neg[DV] ? -{1'b0, w_q} : {1'b0, w_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[DV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_sep  <= n_sep;
            r_out_cos  <= n_cos;
            r_out_coin <= w_coin;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {r_out_cos, r_out_sep};
    assign m_tuser  = r_out_coin;

    a_coin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
        else $error("coincident result with nonzero payload");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (($signed(m_tdata[63:32]) <= 32'sh4000_0000) &&
                      ($signed(m_tdata[63:32]) >= -32'sh4000_0000)))
        else $error("polar cosine out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_sq_vld[0]) && $stable(r_dv_vld[0]) && $stable(r_b_vld)))
        else $error("pipeline moved during stall");

    a_cfg_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == mips_pkg::CFG_BOX_X) |=> (r_len_x == $past(i_cfg_data)))
        else $error("box length x write lost");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// testbench for min_image_pair_separation_top: wrap, root and cosine checked per pair
// depends on mips_pkg and the block under test; predicts each result and compares in order
`default_nettype none

module tb_top;
    localparam int LEN_W     = mips_pkg::LEN_W;
    localparam int CFG_IDX_W = mips_pkg::CFG_IDX_W;

    typedef struct packed {
        logic [31:0] sep;
        logic [31:0] cosv;
        logic        coin;
    } t_pair_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]     i_cfg_data = '0;

    logic [LEN_W-1:0] box_len [3];
    t_pair_result pending_results [$];
    int  n_errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    min_image_pair_separation_top dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic signed [34:0] wrap_axis(logic signed [34:0] d,
                                                     logic [LEN_W-1:0] len);
        logic signed [34:0] l, lo, hi;
        l  = $signed({4'd0, len});
        lo = d - l;
        hi = d + l;
        if ((lo < 0 ? -lo : lo) < (d < 0 ? -d : d)) return lo;
        if ((hi < 0 ? -hi : hi) < (d < 0 ? -d : d)) return hi;
        return d;
    endfunction

    function automatic t_pair_result predict_pair(logic [191:0] p);
        logic signed [34:0] d [3];
        logic [34:0] m [3];
        logic [71:0] sum, cand;
        logic [35:0] root;
        logic [71:0] q;
        t_pair_result r;
        for (int a = 0; a < 3; a++) begin
            d[a] = wrap_axis(35'($signed(p[a*32 +: 32])) - 35'($signed(p[(a+3)*32 +: 32])),
                             box_len[a]);
            m[a] = d[a] < 0 ? -d[a] : d[a];
        end
        sum = 72'(m[0]) * m[0] + 72'(m[1]) * m[1] + 72'(m[2]) * m[2];
        root = '0;
        for (int b = 35; b >= 0; b--) begin
            cand = 72'(root | (36'd1 << b));
            if (cand * cand <= sum) root = root | (36'd1 << b);
        end
        r.sep = root > 36'hFFFF_FFFF ? 32'hFFFF_FFFF : root[31:0];
        r.coin = root == 0;
        r.cosv = '0;
        if (root != 0) begin
            q = (72'(m[2]) << 30) / root;
            if (q > (72'd1 << 30)) q = 72'd1 << 30;
            r.cosv = d[2] < 0 ? -q[31:0] : q[31:0];
        end
        return r;
    endfunction

    task automatic send_pair(logic [191:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        pending_results.push_back(predict_pair(p));
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_box(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == mips_pkg::CFG_BOX_X) box_len[0] = v;
        else if (idx == mips_pkg::CFG_BOX_Y) box_len[1] = v;
        else if (idx == mips_pkg::CFG_BOX_Z) box_len[2] = v;
        @(posedge i_clk);
    endtask

    task automatic set_boxes(logic [LEN_W-1:0] x, logic [LEN_W-1:0] y, logic [LEN_W-1:0] z);
        drain();
        write_box(mips_pkg::CFG_BOX_X, x);
        write_box(mips_pkg::CFG_BOX_Y, y);
        write_box(mips_pkg::CFG_BOX_Z, z);
    endtask

    function automatic logic [191:0] pack_pair(logic [31:0] ax, logic [31:0] ay,
        logic [31:0] az, logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        return {bz, by, bx, az, ay, ax};
    endfunction

    function automatic logic [31:0] rand_pos(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 400000)) - 200000);
            default: return $urandom & 32'h8000_FFFF;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] rand_len;
        logic [31:0] v;
        case ($urandom_range(3))
            0: begin
                v = $urandom;
                return v[LEN_W-1:0];
            end
            1: begin
                v = $urandom_range(0, 300000);
                return v[LEN_W-1:0];
            end
            2: return '0;
            default: return {LEN_W{1'b1}};
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result sep=%h cos=%h coin=%b",
                         $time, m_tdata[31:0], m_tdata[63:32], m_tuser);
                n_errors++;
            end else begin
                t_pair_result e;
                e = pending_results.pop_front();
                if (m_tdata[31:0] !== e.sep) begin
                    $display("%0t separation exp %h got %h", $time, e.sep, m_tdata[31:0]);
                    n_errors++;
                end
                if (m_tdata[63:32] !== e.cosv) begin
                    $display("%0t polar_cosine exp %h got %h", $time, e.cosv, m_tdata[63:32]);
                    n_errors++;
                end
                if (m_tuser !== e.coin) begin
                    $display("%0t coincident exp %b got %b", $time, e.coin, m_tuser);
                    n_errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_directed;
        logic [31:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7FFF_FFFF;
        send_pair(pack_pair(0, 0, 0, 0, 0, 0));
        send_pair(pack_pair(5, 7, 9, 5, 7, 9));
        send_pair(pack_pair(0, 0, 32'h0000_8000, 0, 0, 0));
        send_pair(pack_pair(0, 0, 32'h0000_8001, 0, 0, 0));
        send_pair(pack_pair(32'h0000_C000, 0, 0, 0, 0, 0));
        send_pair(pack_pair(0, 0, 32'h0000_3000, 0, 0, 32'h0000_F000));
        send_pair(pack_pair(mx, mx, mx, mn, mn, mn));
        send_pair(pack_pair(mn, mn, mn, mx, mx, mx));
        set_boxes('0, '0, '0);
        send_pair(pack_pair(mx, mx, mx, mn, mn, mn));
        send_pair(pack_pair(mn, 0, mn, mx, 0, mx));
        send_pair(pack_pair(0, 0, 32'h0001_0000, 0, 0, 0));
        send_pair(pack_pair(0, 0, 32'hFFFF_0000, 0, 0, 0));
        send_pair(pack_pair(3, 0, 0, 0, 0, 0));
        set_boxes({LEN_W{1'b1}}, {LEN_W{1'b1}}, {LEN_W{1'b1}});
        send_pair(pack_pair(mx, mx, mx, mn, mn, mn));
        send_pair(pack_pair(mn, mn, mn, mx, mx, mx));
        send_pair(pack_pair(mx, 0, 0, 0, 0, 0));
        send_pair(pack_pair(0, 0, mn, 0, 0, 0));
        set_boxes(31'd200, 31'd3, 31'd1);
        send_pair(pack_pair(100, 0, 0, 0, 0, 0));
        send_pair(pack_pair(0, 32'hFFFF_FFFE, 1, 0, 0, 0));
    endtask

    task automatic test_random(int count, int idle, int stall);
        int mode;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(2);
            if ($urandom_range(9) == 0)
                send_pair(pack_pair(rand_pos(mode), rand_pos(mode), rand_pos(mode),
                    rand_pos(mode), rand_pos(mode), rand_pos(mode)) & {6{32'hFFFF_FFFF}});
            else
                send_pair({rand_pos(mode), rand_pos(mode), rand_pos(mode),
                           rand_pos(mode), rand_pos(mode), rand_pos(mode)});
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        box_len[0] = mips_pkg::LEN_RESET;
        box_len[1] = mips_pkg::LEN_RESET;
        box_len[2] = mips_pkg::LEN_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        for (int ph = 0; ph < 8; ph++) begin
            set_boxes(rand_len(), rand_len(), rand_len());
            case (ph % 4)
                0: test_random(115, 0, 0);
                1: test_random(115, 49, 0);
                2: test_random(115, 0, 49);
                default: test_random(115, 29, 29);
            endcase
        end
        drain();
        if (n_errors == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

`default_nettype wire
